// File: rtl/clsr_pkg.sv
// shared constants, state encoding and control structs for the shuffled combined lcg
package clsr_pkg;

  localparam int GEN_W  = 31;
  localparam int MUL_W  = 16;
  localparam int PROD_W = GEN_W + MUL_W;
  localparam int FOLD_W = 8;

  localparam logic [MUL_W-1:0]  MUL1 = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL2 = 16'd40692;
  localparam logic [GEN_W-1:0]  MOD1 = 31'd2147483563;
  localparam logic [GEN_W-1:0]  MOD2 = 31'd2147483399;
  // 2^31 mod each modulus, used to fold the high part of a product
  localparam logic [FOLD_W-1:0] FOLD1 = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD2 = 8'd249;

  localparam logic [GEN_W-1:0] GEN1_RESET  = 31'd1;
  localparam logic [GEN_W-1:0] GEN2_RESET  = 31'd123456789;
  localparam longint           WRAP_SPAN   = 64'd2147483562;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_MUL,
    ST_WARM_RED,
    ST_DRAW_MUL,
    ST_DRAW_RED,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_t;

  typedef struct packed {
    logic load_seed;
    logic mul_en;
    logic warm_red;
    logic warm_wr;
    logic warm_last;
    logic draw_red;
    logic rd_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } status_t;

endpackage

// File: rtl/combined_lcg_shuffle_rng.sv
// top level of the shuffled combined lcg random number generator
//
// Input channel (in_valid/in_ready): one beat is one command. in_command
// selects a draw or a reseed; in_seed is used by a reseed only, 0 acts as 1.
// Output channel (out_valid/out_ready): exactly one beat per input beat,
// out_sample in 1..2147483562, in input order.
// A reseed runs the warm-up steps and then a draw. Each generator step
// passes through the product register and the fold-and-reduce stage; a
// draw adds a table read and a write-back. A new command is taken only
// once the previous result is loaded into the output register, in the
// same cycle as that load.
// A finished result waits in the output register; while out_ready is low
// and that register is full, the last draw stage holds and no new beat is
// taken, so nothing is lost.
// Reset loads the generators with 1 and 123456789, clears the last sample,
// and marks every table entry as zero.
module combined_lcg_shuffle_rng #(
  parameter int TABLE_DEPTH  = 32,
  parameter int WARMUP_EXTRA = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [clsr_pkg::GEN_W-1:0] in_seed,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [clsr_pkg::GEN_W-1:0] out_sample
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  clsr_pkg::cmd_t    cmd;
  clsr_pkg::status_t status;
  logic [IDX_W-1:0]  warm_idx;

  clsr_ctrl #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .WARMUP_EXTRA (WARMUP_EXTRA)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .status     (status),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .warm_idx   (warm_idx)
  );

  clsr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_seed    (in_seed),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .warm_idx   (warm_idx),
    .status     (status),
    .out_valid  (out_valid),
    .out_sample (out_sample)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while previous command still in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output register overwritten while result pending");

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mul_en, cmd.warm_red, cmd.draw_red, cmd.rd_en, cmd.out_load}))
    else $error("more than one datapath phase issued");
`endif

endmodule

// File: rtl/clsr_ctrl.sv
// sequencer for warm-up and draw phases of the shuffled combined lcg
module clsr_ctrl #(
  parameter int TABLE_DEPTH  = 32,
  parameter int WARMUP_EXTRA = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_command,
  input  clsr_pkg::status_t                status,
  output logic                             in_ready,
  output clsr_pkg::cmd_t                   cmd,
  output logic [$clog2(TABLE_DEPTH)-1:0]   warm_idx
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int WARM_N = TABLE_DEPTH + WARMUP_EXTRA;
  localparam int CNT_W  = $clog2(WARM_N + 1);

  clsr_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             take;

  assign take     = in_valid & in_ready;
  assign warm_idx = cnt_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clsr_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      clsr_pkg::ST_IDLE, clsr_pkg::ST_DRAW_OUT: begin
        if (state_r == clsr_pkg::ST_DRAW_OUT && !status.out_stall) begin
          state_nxt = clsr_pkg::ST_IDLE;
        end
        if (take) begin
          if (in_command == clsr_pkg::CMD_RESEED) begin
            state_nxt = clsr_pkg::ST_WARM_MUL;
            cnt_nxt   = CNT_W'(WARM_N - 1);
          end else begin
            state_nxt = clsr_pkg::ST_DRAW_MUL;
          end
        end
      end
      clsr_pkg::ST_WARM_MUL: state_nxt = clsr_pkg::ST_WARM_RED;
      clsr_pkg::ST_WARM_RED: begin
        if (cnt_r == '0) begin
          state_nxt = clsr_pkg::ST_DRAW_MUL;
        end else begin
          state_nxt = clsr_pkg::ST_WARM_MUL;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      clsr_pkg::ST_DRAW_MUL: state_nxt = clsr_pkg::ST_DRAW_RED;
      clsr_pkg::ST_DRAW_RED: state_nxt = clsr_pkg::ST_DRAW_RD;
      clsr_pkg::ST_DRAW_RD:  state_nxt = clsr_pkg::ST_DRAW_OUT;
      default:               state_nxt = clsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      clsr_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_seed = in_valid & (in_command == clsr_pkg::CMD_RESEED);
      end
      clsr_pkg::ST_WARM_MUL: cmd.mul_en = 1'b1;
      clsr_pkg::ST_WARM_RED: begin
        cmd.warm_red  = 1'b1;
        cmd.warm_wr   = (cnt_r < CNT_W'(TABLE_DEPTH));
        cmd.warm_last = (cnt_r == '0);
      end
      clsr_pkg::ST_DRAW_MUL: cmd.mul_en   = 1'b1;
      clsr_pkg::ST_DRAW_RED: cmd.draw_red = 1'b1;
      clsr_pkg::ST_DRAW_RD:  cmd.rd_en    = 1'b1;
      clsr_pkg::ST_DRAW_OUT: begin
        cmd.out_load  = !status.out_stall;
        in_ready      = !status.out_stall;
        cmd.load_seed = !status.out_stall & in_valid &
                        (in_command == clsr_pkg::CMD_RESEED);
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/clsr_datapath.sv
// generator registers, modular multipliers, shuffle table and output register
module clsr_datapath #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [clsr_pkg::GEN_W-1:0]       in_seed,
  input  logic                             out_ready,
  input  clsr_pkg::cmd_t                   cmd,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   warm_idx,
  output clsr_pkg::status_t                status,
  output logic                             out_valid,
  output logic [clsr_pkg::GEN_W-1:0]       out_sample
);

  localparam int     GEN_W  = clsr_pkg::GEN_W;
  localparam int     PROD_W = clsr_pkg::PROD_W;
  localparam int     IDX_W  = $clog2(TABLE_DEPTH);
  localparam longint BUCKET = 64'd1 + (clsr_pkg::WRAP_SPAN / TABLE_DEPTH);
  localparam longint RECIP  = (64'd1 << GEN_W) / BUCKET;
  localparam int     Q_W    = $clog2(RECIP + 1);

  function automatic logic [GEN_W-1:0] mod_fold(
    input logic [PROD_W-1:0]           p,
    input logic [clsr_pkg::FOLD_W-1:0] d,
    input logic [GEN_W-1:0]            m
  );
    logic [clsr_pkg::MUL_W+clsr_pkg::FOLD_W-1:0] hd;
    logic [GEN_W:0]                              s1;
    logic [GEN_W:0]                              s2;
    logic [GEN_W:0]                              r;
    hd = p[PROD_W-1:GEN_W] * d;
    s1 = (GEN_W+1)'(hd) + {1'b0, p[GEN_W-1:0]};
    s2 = {1'b0, s1[GEN_W-1:0]} + (s1[GEN_W] ? (GEN_W+1)'(d) : '0);
    r  = (s2 >= {1'b0, m}) ? s2 - {1'b0, m} : s2;
    return r[GEN_W-1:0];
  endfunction

  logic [GEN_W-1:0]  gen1_r, gen1_nxt;
  logic [GEN_W-1:0]  gen2_r, gen2_nxt;
  logic [GEN_W-1:0]  last_r, last_nxt;
  logic [GEN_W-1:0]  out_sample_r;
  logic              out_valid_r, out_valid_nxt;
  logic [PROD_W-1:0] prod1_r, prod2_r;
  logic [Q_W-1:0]    q0_r;
  logic [IDX_W-1:0]  idx_r;
  logic [GEN_W-1:0]  rd_data_r;
  logic              rd_valid_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [GEN_W-1:0]  tbl_mem [TABLE_DEPTH];

  logic [GEN_W-1:0]     seed_eff;
  logic [GEN_W-1:0]     gen1_red;
  logic [GEN_W+Q_W-1:0] qprod;
  logic [Q_W+GEN_W:0]   lim;
  logic [Q_W-1:0]       q_corr;
  logic [IDX_W-1:0]     idx_calc;
  logic [GEN_W-1:0]     rd_eff;
  logic [GEN_W:0]       diff;
  logic [GEN_W:0]       wrapped;
  logic [GEN_W-1:0]     sample;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [GEN_W-1:0]     wr_data;

  assign seed_eff = (in_seed == '0) ? GEN_W'(1) : in_seed;
  assign gen1_red = mod_fold(prod1_r, clsr_pkg::FOLD1, clsr_pkg::MOD1);

  // table index = last / bucket, by reciprocal with one correction step
  assign qprod  = last_r * Q_W'(RECIP);
  assign lim    = ((Q_W+GEN_W+1)'(q0_r) + 1'b1) * (Q_W+GEN_W+1)'(BUCKET);
  assign q_corr = ({{(Q_W+1){1'b0}}, last_r} >= lim) ? q0_r + 1'b1 : q0_r;
  assign idx_calc = (q_corr > Q_W'(TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1)
                                                     : q_corr[IDX_W-1:0];

  assign rd_eff  = rd_valid_r ? rd_data_r : '0;
  assign diff    = {1'b0, rd_eff} - {1'b0, gen2_r};
  assign wrapped = (diff[GEN_W] || diff == '0) ? diff + (GEN_W+1)'(clsr_pkg::WRAP_SPAN)
                                               : diff;
  assign sample  = wrapped[GEN_W-1:0];

  assign wr_en   = cmd.out_load | cmd.warm_wr;
  assign wr_idx  = cmd.out_load ? idx_r : warm_idx;
  assign wr_data = cmd.out_load ? gen1_r : gen1_red;

  always_comb begin
    gen1_nxt = gen1_r;
    gen2_nxt = gen2_r;
    last_nxt = last_r;
    if (cmd.load_seed) begin
      gen1_nxt = seed_eff;
      gen2_nxt = seed_eff;
    end
    if (cmd.warm_red || cmd.draw_red) begin
      gen1_nxt = gen1_red;
    end
    if (cmd.draw_red) begin
      gen2_nxt = mod_fold(prod2_r, clsr_pkg::FOLD2, clsr_pkg::MOD2);
    end
    if (cmd.warm_last) begin
      last_nxt = gen1_red;
    end
    if (cmd.out_load) begin
      last_nxt = sample;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen1_r      <= clsr_pkg::GEN1_RESET;
      gen2_r      <= clsr_pkg::GEN2_RESET;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      gen1_r      <= gen1_nxt;
      gen2_r      <= gen2_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod1_r <= gen1_r * clsr_pkg::MUL1;
      prod2_r <= gen2_r * clsr_pkg::MUL2;
      q0_r    <= qprod[GEN_W +: Q_W];
    end
    if (cmd.draw_red) begin
      idx_r <= idx_calc;
    end
    if (cmd.rd_en) begin
      rd_data_r  <= tbl_mem[idx_r];
      rd_valid_r <= valid_r[idx_r];
    end
    if (cmd.out_load) begin
      out_sample_r <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_idx] <= wr_data;
    end
  end

  assign status.out_stall = out_valid_r & ~out_ready;
  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;

endmodule
